// File: rtl/cartridge_bank_mapper_with_irq_unit_defines.svh
// Assertion macros shared by the mapper RTL.
`ifndef CARTRIDGE_BANK_MAPPER_WITH_IRQ_UNIT_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_IRQ_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define CBM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mapper check failed");

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define CBM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mapper check failed");

`endif

// File: rtl/cbm_pkg.sv
// Types, codes and constants of the cartridge bank mapper.
package cbm_pkg;

	localparam int PORT_RAM_DEPTH_DEF = 128;

	// item function codes
	localparam logic [1:0] FUNC_READ  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_TICK  = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAME_PATCH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOUND_SEL  = 1'b1;

	// game patch codes
	localparam logic [1:0] PATCH_NONE        = 2'd0;
	localparam logic [1:0] PATCH_MIRROR_ONE  = 2'd2;
	localparam logic [1:0] PATCH_MIRROR_HV   = 2'd3;

	// bank kinds
	localparam logic [1:0] KIND_PAT_ROM = 2'd0;
	localparam logic [1:0] KIND_PAT_RAM = 2'd1;
	localparam logic [1:0] KIND_NT_VRAM = 2'd2;
	localparam logic [1:0] KIND_PRG_ROM = 2'd3;

	// mirroring modes
	localparam logic [1:0] MIRROR_VERT   = 2'd0;
	localparam logic [1:0] MIRROR_HORIZ  = 2'd1;
	localparam logic [1:0] MIRROR_ONE_LO = 2'd2;

	// bank slots
	localparam logic [3:0] SLOT_PRG_8000 = 4'd12;
	localparam logic [3:0] SLOT_PRG_A000 = 4'd13;
	localparam logic [3:0] SLOT_PRG_C000 = 4'd14;
	localparam logic [1:0] SLOT_NT_HI    = 2'b10;

	// address map
	localparam logic [15:0] PAGE_MASK  = 16'hF800;
	localparam logic [15:0] PAGE_PORT  = 16'h4800;
	localparam logic [15:0] PAGE_CNT_LO = 16'h5000;
	localparam logic [15:0] PAGE_CNT_HI = 16'h5800;
	localparam logic [15:0] PAGE_PRG0  = 16'hE000;
	localparam logic [15:0] PAGE_PRG1  = 16'hE800;
	localparam logic [15:0] PAGE_PRG2  = 16'hF000;
	localparam logic [15:0] ADDR_PTR   = 16'hF800;

	localparam logic [14:0] IRQ_COUNT_MAX = 15'h7FFF;
	localparam logic [7:0]  PAT_RAM_MIN   = 8'hE0;
	localparam logic [7:0]  NT_ROM_MAX    = 8'hDF;
	localparam logic [7:0]  PAT_RAM_MASK  = 8'h1F;
	localparam logic [7:0]  PRG_MASK      = 8'h3F;
	localparam logic [7:0]  NT_VRAM_MASK  = 8'h01;
	localparam logic [7:0]  PTR_AUTO_INC  = 8'h80;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] address;
		logic [7:0]  data;
		logic [7:0]  cycles;
	} cbm_in_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       forward_to_work_ram;
		logic       irq_line;
		logic       bank_update_valid;
		logic [3:0] bank_slot;
		logic [1:0] bank_kind;
		logic [7:0] bank_number;
		logic       mirroring_valid;
		logic [1:0] mirroring_mode;
	} cbm_out_t;

endpackage

// File: rtl/cbm_in_if.sv
// Request channel interface: valid/ready with one bus access or tick.
interface cbm_in_if;
	import cbm_pkg::*;
	logic    valid;
	logic    ready;
	cbm_in_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/cbm_out_if.sv
// Result channel interface: valid/ready with one mapper result.
interface cbm_out_if;
	import cbm_pkg::*;
	logic     valid;
	logic     ready;
	cbm_out_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/cbm_ram.sv
// Generic single-port RAM with registered read.
module cbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule

// File: rtl/cartridge_bank_mapper_with_irq_unit.sv
// Top level of the cartridge bank mapper with cycle-counting IRQ.
//
// Channels: req carries one item per handshake (bus read, bus write or a
// tick that feeds the IRQ counter); each item gets exactly one result on rsp, in order.
// Both use valid/ready; an item moves on a clock edge with both high.
// cfg_we/cfg_index/cfg_wdata write the game patch and RAM select
// registers; only write them while the unit is idle.
//
// Pipeline: input register (_s1), then one pass of decode, bank and
// counter logic into the result register (_s2). An accepted item is held
// in _s1, then its result is offered from _s2; one item per cycle is
// sustained while rsp takes each result. Port RAM reads use the RAM
// macro's registered read, which lines up with the result register.
//
// Stall: when rsp is not taken the result holds, the s1 item waits and
// req.ready drops once s1 is full; nothing is lost or repeated.
//
// Reset: arst_n resets all control state and clears the sound RAM valid bits
// at once (unwritten sound RAM reads as zero); no clearing pass is needed.
`include "cartridge_bank_mapper_with_irq_unit_defines.svh"

module cartridge_bank_mapper_with_irq_unit #(
	parameter int PORT_RAM_DEPTH = cbm_pkg::PORT_RAM_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cbm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cbm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	cbm_in_if.sink                         req,
	cbm_out_if.source                      rsp
);
	import cbm_pkg::*;

	localparam int IDX_W = $clog2(PORT_RAM_DEPTH);

	// configuration
	logic [1:0] game_patch_q;
	logic       sound_sel_q;

	// mapper state
	logic              lo_rom_q, hi_rom_q;
	logic [7:0]        ptr_q;
	logic              armed_q;
	logic [14:0]       cnt_q;
	logic              irq_q;
	logic [PORT_RAM_DEPTH-1:0] snd_vld_q;

	// pipeline
	logic     vld_s1, vld_s2;
	cbm_in_t  item_s1;
	cbm_out_t res_s2;
	logic     port_rd_s2, sel_snd_s2, snd_hit_s2;
	logic     advance;

	// next state and result of the item in s1
	logic              lo_rom_d, hi_rom_d, armed_d, irq_d;
	logic [7:0]        ptr_d;
	logic [14:0]       cnt_d;
	cbm_out_t          res_d;
	logic              port_rd, port_wr, ptr_wr;
	logic [IDX_W-1:0]  idx;
	logic [15:0]       tick_sum;
	logic [7:0]        snd_rdata, win_rdata;

	assign advance   = vld_s1 && (!vld_s2 || rsp.ready);
	assign req.ready = !vld_s1 || advance;
	assign idx       = ptr_q[IDX_W-1:0];
	assign tick_sum  = {1'b0, cnt_q} + {8'd0, item_s1.cycles};

	always_comb begin
		logic [15:0] a;
		logic [15:0] page;
		logic [7:0]  d;
		logic        rom_only;
		a        = item_s1.address;
		d        = item_s1.data;
		page     = a & PAGE_MASK;
		rom_only = a[13] ? hi_rom_q : lo_rom_q;
		lo_rom_d = lo_rom_q;
		hi_rom_d = hi_rom_q;
		armed_d  = armed_q;
		irq_d    = irq_q;
		ptr_d    = ptr_q;
		cnt_d    = cnt_q;
		port_rd  = 1'b0;
		port_wr  = 1'b0;
		ptr_wr   = 1'b0;
		res_d    = '0;
		unique case (item_s1.func)
			FUNC_READ: begin
				priority if (page == PAGE_PORT) begin
					port_rd = (a == PAGE_PORT);
				end else if (page == PAGE_CNT_LO) begin
					res_d.read_data = cnt_q[7:0];
				end else if (page == PAGE_CNT_HI) begin
					res_d.read_data = {1'b0, cnt_q[14:8]};
				end else if (a[15:13] == 3'b011) begin
					res_d.forward_to_work_ram = 1'b1;
				end else begin
					res_d.read_data = a[15:8];
				end
			end
			FUNC_WRITE: begin
				priority if (page == PAGE_PORT) begin
					port_wr = (a == PAGE_PORT);
				end else if (page == PAGE_CNT_LO) begin
					cnt_d = {cnt_q[14:8], d};
					irq_d = 1'b0;
				end else if (page == PAGE_CNT_HI) begin
					cnt_d   = {d[6:0], cnt_q[7:0]};
					armed_d = d[7];
					irq_d   = 1'b0;
				end else if (a[15:13] == 3'b011) begin
					res_d.forward_to_work_ram = 1'b1;
				end else if (a[15:14] == 2'b10) begin
					// pattern slots 0-7
					res_d.bank_update_valid = 1'b1;
					res_d.bank_slot         = {1'b0, a[13:11]};
					if (d < PAT_RAM_MIN || rom_only) begin
						res_d.bank_kind   = KIND_PAT_ROM;
						res_d.bank_number = d;
					end else begin
						res_d.bank_kind   = KIND_PAT_RAM;
						res_d.bank_number = d & PAT_RAM_MASK;
					end
				end else if (a[15:13] == 3'b110) begin
					// nametable slots 8-11, blocked by any game patch
					if (game_patch_q == PATCH_NONE) begin
						res_d.bank_update_valid = 1'b1;
						res_d.bank_slot         = {SLOT_NT_HI, a[12:11]};
						if (d <= NT_ROM_MAX) begin
							res_d.bank_kind   = KIND_PAT_ROM;
							res_d.bank_number = d;
						end else begin
							res_d.bank_kind   = KIND_NT_VRAM;
							res_d.bank_number = d & NT_VRAM_MASK;
						end
					end
				end else if (page == PAGE_PRG0) begin
					res_d.bank_update_valid = 1'b1;
					res_d.bank_slot         = SLOT_PRG_8000;
					res_d.bank_kind         = KIND_PRG_ROM;
					res_d.bank_number       = d & PRG_MASK;
					if (game_patch_q == PATCH_MIRROR_ONE) begin
						res_d.mirroring_valid = 1'b1;
						res_d.mirroring_mode  = d[6] ? MIRROR_VERT : MIRROR_ONE_LO;
					end else if (game_patch_q == PATCH_MIRROR_HV) begin
						res_d.mirroring_valid = 1'b1;
						res_d.mirroring_mode  = d[7] ? MIRROR_HORIZ : MIRROR_VERT;
					end
				end else if (page == PAGE_PRG1) begin
					lo_rom_d                = d[6];
					hi_rom_d                = d[7];
					res_d.bank_update_valid = 1'b1;
					res_d.bank_slot         = SLOT_PRG_A000;
					res_d.bank_kind         = KIND_PRG_ROM;
					res_d.bank_number       = d & PRG_MASK;
				end else if (page == PAGE_PRG2) begin
					res_d.bank_update_valid = 1'b1;
					res_d.bank_slot         = SLOT_PRG_C000;
					res_d.bank_kind         = KIND_PRG_ROM;
					res_d.bank_number       = d & PRG_MASK;
				end else if (a == ADDR_PTR) begin
					ptr_wr = 1'b1;
					ptr_d  = d;
				end
			end
			FUNC_TICK: begin
				if (armed_q) begin
					if (tick_sum >= {1'b0, IRQ_COUNT_MAX}) begin
						armed_d = 1'b0;
						cnt_d   = IRQ_COUNT_MAX;
						irq_d   = 1'b1;
					end else begin
						cnt_d = tick_sum[14:0];
					end
				end
			end
			default: begin
			end
		endcase
		// auto-increment after a port access when ptr bit 7 is set
		if ((port_rd || port_wr) && ptr_q[7]) begin
			ptr_d = (ptr_q + 8'd1) | PTR_AUTO_INC;
		end
		res_d.irq_line = irq_d;
	end

	cbm_ram #(.WIDTH(8), .DEPTH(PORT_RAM_DEPTH)) u_snd_ram (
		.clk   (clk),
		.we    (advance && port_wr && sound_sel_q),
		.re    (advance && port_rd && sound_sel_q),
		.addr  (idx),
		.wdata (item_s1.data),
		.rdata (snd_rdata)
	);

	cbm_ram #(.WIDTH(8), .DEPTH(PORT_RAM_DEPTH)) u_win_ram (
		.clk   (clk),
		.we    (advance && port_wr && !sound_sel_q),
		.re    (advance && port_rd && !sound_sel_q),
		.addr  (idx),
		.wdata (item_s1.data),
		.rdata (win_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			game_patch_q <= PATCH_NONE;
			sound_sel_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GAME_PATCH: game_patch_q <= cfg_wdata[1:0];
				CFG_SOUND_SEL:  sound_sel_q  <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_rom_q  <= 1'b0;
			hi_rom_q  <= 1'b0;
			ptr_q     <= '0;
			armed_q   <= 1'b0;
			cnt_q     <= '0;
			irq_q     <= 1'b0;
			snd_vld_q <= '0;
		end else if (advance) begin
			lo_rom_q <= lo_rom_d;
			hi_rom_q <= hi_rom_d;
			ptr_q    <= ptr_d;
			armed_q  <= armed_d;
			cnt_q    <= cnt_d;
			irq_q    <= irq_d;
			if (port_wr && sound_sel_q) begin
				snd_vld_q[idx] <= 1'b1;
			end
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				vld_s1 <= 1'b1;
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			if (advance) begin
				vld_s2 <= 1'b1;
			end else if (rsp.ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.payload;
		end
		if (advance) begin
			res_s2     <= res_d;
			port_rd_s2 <= port_rd;
			sel_snd_s2 <= sound_sel_q;
			snd_hit_s2 <= snd_vld_q[idx];
		end
	end

	always_comb begin
		rsp.payload = res_s2;
		if (port_rd_s2) begin
			if (sel_snd_s2) begin
				rsp.payload.read_data = snd_hit_s2 ? snd_rdata : 8'd0;
			end else begin
				rsp.payload.read_data = win_rdata;
			end
		end
	end
	assign rsp.valid = vld_s2;

	`CBM_ASSERT_NOW(a_irq_sat, $rose(irq_q), (cnt_q == IRQ_COUNT_MAX) && !armed_q)
	`CBM_ASSERT_NOW(a_bank_clear, vld_s2 && !res_s2.bank_update_valid,
		(res_s2.bank_slot == 4'd0) && (res_s2.bank_kind == KIND_PAT_ROM)
		&& (res_s2.bank_number == 8'd0))
	`CBM_ASSERT_NOW(a_mirror_prg, vld_s2 && res_s2.mirroring_valid,
		res_s2.bank_update_valid && (res_s2.bank_slot == SLOT_PRG_8000))
	`CBM_ASSERT_NEXT(a_ptr_sticky, ptr_q[7] && !(advance && ptr_wr), ptr_q[7])
endmodule
